FILE: hdl/multichannel_scaler_top_defines.svh
// Assertion macros used by the scaler checker.
`ifndef MULTICHANNEL_SCALER_TOP_DEFINES_SVH
`define MULTICHANNEL_SCALER_TOP_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define MSC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scaler check failed");

// Check a consequent in the cycle after its antecedent.
`define MSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scaler check failed");

`endif

FILE: hdl/msc_pkg.sv
// Types, codes and defaults for the multichannel scaler.
`default_nettype none
package msc_pkg;

	localparam int DEF_NUM_CHANNELS = 1024;
	localparam int DEF_COUNT_WIDTH  = 32;

	localparam int         CIU_W     = 11;
	localparam logic [10:0] CIU_RESET = 11'd512;

	localparam int OP_ADDR_W = 12;
	localparam int Q_DEPTH   = 2;
	localparam int Q_PW      = $clog2(Q_DEPTH);

	localparam logic [2:0] REQ_PULSE   = 3'd0;
	localparam logic [2:0] REQ_ADVANCE = 3'd1;
	localparam logic [2:0] REQ_SYNC    = 3'd2;
	localparam logic [2:0] REQ_START   = 3'd3;
	localparam logic [2:0] REQ_STOP    = 3'd4;
	localparam logic [2:0] REQ_CLEAR   = 3'd5;
	localparam logic [2:0] REQ_STATUS  = 3'd6;
	localparam logic [2:0] REQ_READ    = 3'd7;

	localparam logic [2:0] RESP_ACK     = 3'd0;
	localparam logic [2:0] RESP_REFUSED = 3'd1;
	localparam logic [2:0] RESP_RUNNING = 3'd2;
	localparam logic [2:0] RESP_STOPPED = 3'd3;
	localparam logic [2:0] RESP_DATA    = 3'd4;

	localparam logic [1:0] OP_BUMP  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_REPLY = 2'd3;

	typedef struct packed {
		logic [2:0] req_type;
		logic [9:0] bin_index;
	} req_t;

	typedef struct packed {
		logic [2:0]  response_code;
		logic [31:0] bin_count;
		logic        running_now;
	} rsp_t;

	typedef struct packed {
		logic [1:0]           kind;
		logic [OP_ADDR_W-1:0] addr;
		logic                 zero;
		logic [2:0]           code;
		logic                 running;
	} op_t;

endpackage
`default_nettype wire

FILE: hdl/msc_front.sv
// Front end: accept requests, keep run control state, issue store operations.
`default_nettype none
module msc_front #(
	parameter int NUM_CHANNELS = msc_pkg::DEF_NUM_CHANNELS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	input  wire logic                     full,
	input  wire msc_pkg::req_t            req,
	input  wire logic                     cfg_we,
	input  wire logic [msc_pkg::CIU_W-1:0] cfg_wdata,
	output logic                          q_push,
	output msc_pkg::op_t                  q_op
);
	import msc_pkg::*;

	localparam int CHW = $clog2(NUM_CHANNELS + 1);

	logic [CHW-1:0]   cur_q, cur_d;
	logic             run_q, run_d;
	logic             arm_q, arm_d;
	logic             stp_q, stp_d;
	logic             spp_q, spp_d;
	logic [CIU_W-1:0] ciu_q;
	logic             acc;

	assign acc = push && !full;

	always_comb begin
		cur_d = cur_q;
		run_d = run_q;
		arm_d = arm_q;
		stp_d = stp_q;
		spp_d = spp_q;
		q_push = 1'b0;
		q_op.kind = OP_REPLY;
		q_op.addr = '0;
		q_op.zero = 1'b0;
		q_op.code = RESP_ACK;
		q_op.running = run_q;
		if (acc) begin
			case (req.req_type)
				REQ_PULSE: begin
					if (run_q) begin
						if (32'(cur_q) < NUM_CHANNELS) begin
							q_push = 1'b1;
							q_op.kind = OP_BUMP;
							q_op.addr = OP_ADDR_W'(cur_q);
						end else if (32'(cur_q) == 32'(ciu_q)) begin
							// one past the end wraps to bin 0 on a full sweep
							q_push = 1'b1;
							q_op.kind = OP_BUMP;
						end
					end
				end
				REQ_ADVANCE: begin
					if (run_q && 32'(cur_q) < NUM_CHANNELS)
						cur_d = CHW'(cur_q + 1'b1);
				end
				REQ_SYNC: begin
					if (arm_q) begin
						if (stp_q)
							run_d = 1'b1;
						if (spp_q) begin
							run_d = 1'b0;
							arm_d = 1'b0;
						end
						stp_d = 1'b0;
						spp_d = 1'b0;
						cur_d = '0;
					end
				end
				REQ_START: begin
					stp_d = 1'b1;
					arm_d = 1'b1;
					q_push = 1'b1;
				end
				REQ_STOP: begin
					spp_d = 1'b1;
					q_push = 1'b1;
				end
				REQ_CLEAR: begin
					q_push = 1'b1;
					if (run_q)
						q_op.code = RESP_REFUSED;
					else
						q_op.kind = OP_CLEAR;
				end
				REQ_STATUS: begin
					q_push = 1'b1;
					q_op.code = run_q ? RESP_RUNNING : RESP_STOPPED;
				end
				default: begin
					q_push = 1'b1;
					q_op.kind = OP_READ;
					q_op.addr = OP_ADDR_W'(req.bin_index);
					q_op.zero = !(32'(req.bin_index) < NUM_CHANNELS);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			run_q <= 1'b0;
			arm_q <= 1'b0;
			stp_q <= 1'b0;
			spp_q <= 1'b0;
			ciu_q <= CIU_RESET;
		end else begin
			cur_q <= cur_d;
			run_q <= run_d;
			arm_q <= arm_d;
			stp_q <= stp_d;
			spp_q <= spp_d;
			if (cfg_we && !run_q)
				ciu_q <= cfg_wdata;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/msc_fifo.sv
// Short operation queue between the front and back ends.
`default_nettype none
module msc_fifo (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr,
	input  wire msc_pkg::op_t wdata,
	output logic              q_full,
	input  wire logic         rd,
	output logic              q_empty,
	output msc_pkg::op_t      rdata
);
	import msc_pkg::*;

	op_t             slot_q [Q_DEPTH];
	logic [Q_PW-1:0] wp_q, rp_q;
	logic [Q_PW:0]   cnt_q;
	logic            do_wr, do_rd;

	assign q_full  = (32'(cnt_q) == Q_DEPTH);
	assign q_empty = (cnt_q == '0);
	assign rdata   = slot_q[rp_q];
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= (32'(wp_q) == Q_DEPTH - 1) ? '0 : Q_PW'(wp_q + 1'b1);
			if (do_rd)
				rp_q <= (32'(rp_q) == Q_DEPTH - 1) ? '0 : Q_PW'(rp_q + 1'b1);
			if (do_wr && !do_rd)
				cnt_q <= (Q_PW + 1)'(cnt_q + 1'b1);
			else if (do_rd && !do_wr)
				cnt_q <= (Q_PW + 1)'(cnt_q - 1'b1);
		end
	end

endmodule
`default_nettype wire

FILE: hdl/msc_back.sv
// Back end: counter store, read-modify-write, clear sweeps and result register.
`default_nettype none
module msc_back #(
	parameter int NUM_CHANNELS = msc_pkg::DEF_NUM_CHANNELS,
	parameter int COUNT_WIDTH  = msc_pkg::DEF_COUNT_WIDTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_empty,
	input  wire msc_pkg::op_t q_head,
	output logic              q_pop,
	output logic              init_busy,
	output logic              empty,
	input  wire logic         pop,
	output msc_pkg::rsp_t     rsp
);
	import msc_pkg::*;

	localparam int AW = $clog2(NUM_CHANNELS);

	localparam logic [2:0] B_INIT  = 3'd0;
	localparam logic [2:0] B_IDLE  = 3'd1;
	localparam logic [2:0] B_BUMP  = 3'd2;
	localparam logic [2:0] B_READ  = 3'd3;
	localparam logic [2:0] B_CLEAR = 3'd4;
	localparam logic [2:0] B_ACK   = 3'd5;

	logic [COUNT_WIDTH-1:0] store [NUM_CHANNELS];
	logic [COUNT_WIDTH-1:0] rd_q;

	logic [2:0]             state_q, state_d;
	logic [AW-1:0]          sweep_q, addr_q;
	logic                   zero_q, run_q;
	logic                   out_valid_q;
	rsp_t                   rsp_q, load_val;
	logic                   load, out_free, sweep_last;
	logic                   mem_we, mem_re;
	logic [AW-1:0]          mem_wa, mem_ra;
	logic [COUNT_WIDTH-1:0] mem_wd;

	assign out_free   = !out_valid_q || pop;
	assign sweep_last = (32'(sweep_q) == NUM_CHANNELS - 1);
	assign init_busy  = (state_q == B_INIT);
	assign empty      = !out_valid_q;
	assign rsp        = rsp_q;

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		mem_we = 1'b0;
		mem_wa = sweep_q;
		mem_wd = '0;
		mem_re = 1'b0;
		mem_ra = q_head.addr[AW-1:0];
		load = 1'b0;
		load_val.response_code = RESP_DATA;
		load_val.bin_count = zero_q ? 32'd0 : 32'(rd_q);
		load_val.running_now = run_q;
		case (state_q)
			B_INIT: begin
				mem_we = 1'b1;
				if (sweep_last)
					state_d = B_IDLE;
			end
			B_IDLE: begin
				if (!q_empty) begin
					case (q_head.kind)
						OP_BUMP: begin
							q_pop = 1'b1;
							mem_re = 1'b1;
							state_d = B_BUMP;
						end
						OP_READ: begin
							q_pop = 1'b1;
							mem_re = 1'b1;
							state_d = B_READ;
						end
						OP_CLEAR: begin
							q_pop = 1'b1;
							state_d = B_CLEAR;
						end
						default: begin
							if (out_free) begin
								q_pop = 1'b1;
								load = 1'b1;
								load_val.response_code = q_head.code;
								load_val.bin_count = 32'd0;
								load_val.running_now = q_head.running;
							end
						end
					endcase
				end
			end
			B_BUMP: begin
				mem_we = 1'b1;
				mem_wa = addr_q;
				mem_wd = rd_q + 1'b1;
				state_d = B_IDLE;
			end
			B_READ: begin
				if (out_free) begin
					load = 1'b1;
					state_d = B_IDLE;
				end
			end
			B_CLEAR: begin
				mem_we = 1'b1;
				if (sweep_last)
					state_d = B_ACK;
			end
			B_ACK: begin
				if (out_free) begin
					load = 1'b1;
					load_val.response_code = RESP_ACK;
					load_val.bin_count = 32'd0;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// single write port, single registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			store[mem_wa] <= mem_wd;
		if (mem_re)
			rd_q <= store[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			addr_q <= q_head.addr[AW-1:0];
			zero_q <= q_head.zero;
			run_q <= q_head.running;
		end
		if (load)
			rsp_q <= load_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_INIT;
			sweep_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_INIT || state_q == B_CLEAR)
				sweep_q <= sweep_last ? '0 : AW'(sweep_q + 1'b1);
			if (load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/multichannel_scaler_top.sv
// Multichannel scaler: pulse histogram over a channel sweep, queue interface.
// Path: a reply-only request (start, stop, status, refused clear) passes
// through the queue to the result register; a bin read also passes through
// the store's registered read port. A pulse reads the counter store, then
// writes it back; a clear sweeps every bin, then acknowledges.
// Reset: async, active low; then full stays high while the store is swept
// to zero.
`default_nettype none
module multichannel_scaler_top #(
	parameter int NUM_CHANNELS = msc_pkg::DEF_NUM_CHANNELS,
	parameter int COUNT_WIDTH  = msc_pkg::DEF_COUNT_WIDTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output logic                           full,
	input  wire msc_pkg::req_t             req,
	output logic                           empty,
	input  wire logic                      pop,
	output msc_pkg::rsp_t                  rsp,
	input  wire logic                      cfg_we,
	input  wire logic [msc_pkg::CIU_W-1:0] cfg_wdata
);
	import msc_pkg::*;

	// front -> queue
	logic q_push;
	op_t  q_op;
	logic q_full;

	// queue -> back
	logic q_empty, q_pop;
	op_t  q_head;

	// back end status
	logic init_busy;

	// Hold off new transactions while the queue is full or the store is
	// still being cleared after reset.
	assign full = q_full || init_busy;

	// Front: run control (armed, pending start/stop, current channel) is
	// updated in the cycle of acceptance; store work and replies are queued
	// in order so every result leaves in request order.
	msc_front #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_push   (q_push),
		.q_op     (q_op)
	);

	// Two-entry queue decouples request acceptance from store timing.
	msc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_op),
		.q_full (q_full),
		.rd     (q_pop),
		.q_empty(q_empty),
		.rdata  (q_head)
	);

	// Back: counter store, clear sweeps and the result register, which
	// holds a finished transaction until the consumer pops it.
	msc_back #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.init_busy(init_busy),
		.empty    (empty),
		.pop      (pop),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire

FILE: hdl/msc_checker.sv
// Port-level checker for the scaler and its bind to the top level.
`default_nettype none
`include "multichannel_scaler_top_defines.svh"
module msc_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          empty,
	input wire logic          pop,
	input wire msc_pkg::rsp_t rsp
);
	import msc_pkg::*;

	`MSC_ASSERT_NEXT(a_rsp_hold, !empty && !pop, !empty && $stable(rsp))
	`MSC_ASSERT_NOW(a_code_legal, !empty, rsp.response_code <= RESP_DATA)
	`MSC_ASSERT_NOW(a_count_zero, !empty && rsp.response_code != RESP_DATA, rsp.bin_count == 32'd0)
	`MSC_ASSERT_NOW(a_stat_run, !empty && rsp.response_code == RESP_RUNNING, rsp.running_now)
	`MSC_ASSERT_NOW(a_stat_stop, !empty && rsp.response_code == RESP_STOPPED, !rsp.running_now)

endmodule

bind multichannel_scaler_top msc_checker u_msc_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.empty (empty),
	.pop   (pop),
	.rsp   (rsp)
);
`default_nettype wire

FILE: verif/multichannel_scaler_top_tb.sv
// Self-checking testbench for the multichannel scaler: queue-style stimulus and result check.
`default_nettype none
module multichannel_scaler_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import msc_pkg::*;

	localparam int NCH = DEF_NUM_CHANNELS;
	// A clear walks the whole store before the back end frees up, so let that
	// much time pass after the last result before touching the register.
	localparam int SETTLE_CYCLES = NCH + 16;
	// Longest honest quiet spell: reset sweep or clear walk plus a settle wait
	// plus receiver stalls; take it several times over.
	localparam int WATCH_LIMIT = 10 * NCH + 1000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	req_t        req = '0;
	logic        empty;
	logic        pop = 1'b0;
	rsp_t        rsp;
	logic        cfg_we = 1'b0;
	logic [10:0] cfg_wdata = '0;

	multichannel_scaler_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Requests waiting to be presented, and replies the scaler still owes.
	req_t pending_reqs[$];
	rsp_t expected_rsps[$];

	// Shadow of the scaler state.
	logic [31:0] bin_model [NCH];
	int unsigned chan_model = 0;
	bit          run_model = 1'b0;
	bit          armed_model = 1'b0;
	bit          start_model = 1'b0;
	bit          stop_model = 1'b0;
	logic [10:0] ciu_model = CIU_RESET;

	logic req_fire = 1'b0;
	int   idle_pct = 37;
	int   idle_cycles = 0;
	int   err_count = 0;
	int   queued_items = 0;
	int   items_accepted = 0;
	int   results_checked = 0;
	int   pulses_counted = 0;
	int   pulses_folded = 0;
	int   pulses_dropped = 0;
	int   clears_refused = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch on %s: got 'h%0h, expected 'h%0h", $realtime, what, got, want);
		err_count++;
	endtask

	// Apply one accepted request to the shadow state; queue its reply if any.
	task automatic model_request(input req_t r);
		rsp_t o;
		bit   has_rsp;
		has_rsp = 1'b1;
		o = '0;
		o.response_code = RESP_ACK;
		case (r.req_type)
			REQ_PULSE: begin
				has_rsp = 1'b0;
				if (run_model) begin
					if (chan_model < NCH) begin
						bin_model[chan_model] = bin_model[chan_model] + 32'd1;
						pulses_counted++;
					end else if (chan_model == ciu_model) begin
						// one past the last channel folds into bin 0 on a full-size sweep
						bin_model[0] = bin_model[0] + 32'd1;
						pulses_folded++;
					end else begin
						pulses_dropped++;
					end
				end
			end
			REQ_ADVANCE: begin
				has_rsp = 1'b0;
				if (run_model && chan_model < NCH)
					chan_model++;
			end
			REQ_SYNC: begin
				has_rsp = 1'b0;
				if (armed_model) begin
					if (start_model)
						run_model = 1'b1;
					if (stop_model) begin
						run_model = 1'b0;
						armed_model = 1'b0;
					end
					start_model = 1'b0;
					stop_model = 1'b0;
					chan_model = 0;
				end
			end
			REQ_START: begin
				start_model = 1'b1;
				armed_model = 1'b1;
			end
			REQ_STOP: stop_model = 1'b1;
			REQ_CLEAR: begin
				if (run_model) begin
					o.response_code = RESP_REFUSED;
					clears_refused++;
				end else begin
					foreach (bin_model[i])
						bin_model[i] = '0;
				end
			end
			REQ_STATUS: o.response_code = run_model ? RESP_RUNNING : RESP_STOPPED;
			default: begin
				o.response_code = RESP_DATA;
				if (r.bin_index < NCH)
					o.bin_count = bin_model[r.bin_index];
			end
		endcase
		o.running_now = run_model;
		if (has_rsp)
			expected_rsps.push_back(o);
	endtask

	// Driver: change inputs on the falling edge.
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
			pop <= 1'b0;
		end else begin
			// drop the transaction the last rising edge took
			if (req_fire)
				pending_reqs.delete(0);
			// hold a request that has not been taken yet
			if (!(push && !req_fire)) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
					push <= 1'b1;
					req <= pending_reqs[0];
				end else begin
					push <= 1'b0;
				end
			end
			pop <= ($urandom_range(99) >= idle_pct);
		end
	end

	// Monitor: sample both handshakes on the rising edge.
	always @(posedge clk) begin : monitor
		rsp_t want;
		req_fire <= arst_n && push && !full;
		if (arst_n && push && !full) begin
			model_request(req);
			items_accepted++;
		end
		if (arst_n && pop && !empty) begin
			if (expected_rsps.size() == 0) begin
				report_mismatch("result with nothing pending", 32'(rsp.response_code),
					32'd0);
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.response_code !== want.response_code)
					report_mismatch("response_code", 32'(rsp.response_code),
						32'(want.response_code));
				if (rsp.bin_count !== want.bin_count)
					report_mismatch("bin_count", rsp.bin_count, want.bin_count);
				if (rsp.running_now !== want.running_now)
					report_mismatch("running_now", 32'(rsp.running_now),
						32'(want.running_now));
				results_checked++;
			end
		end
		if ((arst_n && push && !full) || (arst_n && pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// Watchdog: end the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $realtime, idle_cycles);
			$display("multichannel_scaler_top_tb: done, errors");
			$finish;
		end
	end

	function automatic logic [9:0] any_bin();
		return 10'($urandom_range(NCH - 1));
	endfunction

	task automatic add_req(input logic [2:0] kind, input logic [9:0] idx);
		req_t r;
		r.req_type = kind;
		r.bin_index = idx;
		pending_reqs.push_back(r);
		queued_items++;
	endtask

	// Let every request go in and every reply come out, then wait out the back end.
	task automatic settle();
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write channels_in_use from an idle block; a write while running is ignored.
	task automatic write_ciu(input logic [10:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		if (!run_model)
			ciu_model = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random sweeps: mostly start/sync/events/stop sequences, some raw noise.
	task automatic short_sweeps(input int count);
		int stop_at;
		int pick;
		stop_at = queued_items + count;
		while (queued_items < stop_at) begin
			if ($urandom_range(3) != 0) begin
				add_req(REQ_START, any_bin());
				add_req(REQ_SYNC, any_bin());
				repeat ($urandom_range(60, 4)) begin
					pick = $urandom_range(99);
					if (pick < 45)
						add_req(REQ_PULSE, any_bin());
					else if (pick < 75)
						add_req(REQ_ADVANCE, any_bin());
					else if (pick < 85)
						add_req(REQ_READ, 10'($urandom_range(31)));
					else if (pick < 90)
						add_req(REQ_STATUS, any_bin());
					else if (pick < 94)
						add_req(REQ_CLEAR, any_bin());
					else if (pick < 97)
						add_req(REQ_SYNC, any_bin());
					else
						add_req(REQ_READ, any_bin());
				end
				if ($urandom_range(4) != 0) begin
					add_req(REQ_STOP, any_bin());
					repeat ($urandom_range(3)) add_req(REQ_PULSE, any_bin());
					add_req(REQ_SYNC, any_bin());
					repeat ($urandom_range(4, 1))
						add_req(REQ_READ, 10'($urandom_range(31)));
					if ($urandom_range(3) == 0)
						add_req(REQ_CLEAR, any_bin());
				end
			end else begin
				repeat ($urandom_range(12, 1))
					add_req(3'($urandom_range(7)), any_bin());
			end
		end
	endtask

	// Walk a whole sweep to the saturation point and pulse past the end.
	// With poke set, try a register write while running halfway through.
	task automatic full_sweep(input bit poke);
		add_req(REQ_START, any_bin());
		add_req(REQ_SYNC, any_bin());
		for (int ch = 0; ch < NCH + 6; ch++) begin
			if ($urandom_range(15) == 0)
				add_req(REQ_PULSE, any_bin());
			if (ch % 97 == 0)
				add_req(REQ_READ, 10'((ch > 0) ? ch - 1 : 0));
			if (poke && ch == NCH / 2)
				write_ciu(11'd1024);
			add_req(REQ_ADVANCE, any_bin());
		end
		repeat (3) add_req(REQ_PULSE, any_bin());
		add_req(REQ_READ, 10'd0);
		add_req(REQ_STATUS, any_bin());
		add_req(REQ_STOP, any_bin());
		add_req(REQ_SYNC, any_bin());
		add_req(REQ_READ, 10'd0);
		add_req(REQ_READ, 10'(NCH - 1));
	endtask

	initial begin
		foreach (bin_model[i])
			bin_model[i] = '0;
		// Assert reset once; the store sweep follows on its own.
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: idle behavior, arming rules, refusal, reads at both ends.
		add_req(REQ_STATUS, 10'd0);
		add_req(REQ_READ, 10'd0);
		add_req(REQ_READ, 10'd1023);
		add_req(REQ_PULSE, 10'd0);       // stopped: ignored
		add_req(REQ_ADVANCE, 10'd0);     // stopped: ignored
		add_req(REQ_SYNC, 10'd0);        // not armed: ignored
		add_req(REQ_CLEAR, 10'd0);       // stopped: store zeroed
		add_req(REQ_STOP, 10'd0);        // stop alone does not arm
		add_req(REQ_SYNC, 10'd0);
		add_req(REQ_START, 10'd0);
		add_req(REQ_SYNC, 10'd0);        // start and stop both pending: stays stopped
		add_req(REQ_STATUS, 10'd0);
		add_req(REQ_START, 10'd0);
		add_req(REQ_SYNC, 10'd0);        // now running
		add_req(REQ_PULSE, 10'd0);
		add_req(REQ_PULSE, 10'd0);
		add_req(REQ_ADVANCE, 10'd0);
		add_req(REQ_PULSE, 10'd0);
		add_req(REQ_CLEAR, 10'd0);       // running: refused
		add_req(REQ_STATUS, 10'd0);
		add_req(REQ_READ, 10'd0);
		add_req(REQ_READ, 10'd1);
		add_req(REQ_STOP, 10'd0);
		add_req(REQ_SYNC, 10'd0);
		add_req(REQ_STATUS, 10'd0);
		add_req(REQ_CLEAR, 10'd0);
		add_req(REQ_READ, 10'd0);

		// Random phases across register settings; each write pauses the sender
		// until the scaler has drained.
		write_ciu(11'd1);
		short_sweeps(40);
		add_req(REQ_STOP, any_bin());
		add_req(REQ_SYNC, any_bin());

		// Full-size sweep, no idling on either side: pulses past the end fold into bin 0.
		write_ciu(11'd1024);
		idle_pct = 0;
		full_sweep(1'b0);
		settle();
		idle_pct = 37;

		write_ciu(11'd0);
		short_sweeps(40);
		add_req(REQ_STOP, any_bin());
		add_req(REQ_SYNC, any_bin());

		// Half-size sweep with an ignored write mid-run: pulses past the end drop.
		write_ciu(11'd512);
		full_sweep(1'b1);

		write_ciu(11'd2047);
		short_sweeps(40);

		settle();
		$display("covered %0d requests, %0d replies checked, %0d counted pulses",
			items_accepted, results_checked, pulses_counted);
		$display("past-end pulses: %0d folded, %0d dropped; %0d clears refused",
			pulses_folded, pulses_dropped, clears_refused);
		if (err_count == 0)
			$display("multichannel_scaler_top_tb: done, clean");
		else
			$display("multichannel_scaler_top_tb: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
